[rtl/elastic_circle_collision_core_assert.svh]
// assertion macros shared by the checker
`ifndef ELASTIC_CIRCLE_COLLISION_CORE_ASSERT_SVH
`define ELASTIC_CIRCLE_COLLISION_CORE_ASSERT_SVH

// same-cycle implication
`define ECC_AST_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECC_AST_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ecc_pkg.sv]
`timescale 1ns / 1ps
package ecc_pkg;

  // sum of squares and root widths
  localparam int SQ_W   = 66;
  localparam int DIST_W = 33;
  // width handed to the saturating function
  localparam int SAT_W  = 40;

  // per-item data that travels beside the sqrt and divider pipelines
  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [31:0]        rsum;
    logic [31:0]        msum;
    logic               mneg;
    logic [30:0]        mdiff;
    logic [30:0]        m1;
    logic [30:0]        m2;
    logic               dx_neg;
    logic               dy_neg;
    logic [DIST_W-1:0]  ax;
    logic [DIST_W-1:0]  ay;
    logic               hit;
    logic               deg;
    logic signed [33:0] ov;
  } side_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7fffffff);
    lo = -SAT_W'(33'sh080000000);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return 32'(x);
    end
  endfunction

endpackage

[rtl/elastic_circle_collision_core.sv]
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid / in_stall | first_*, second_* (pos, vel, mass, radius)
// out     | out_valid/out_stall | hit, degenerate, new_first_*, new_second_vel_*
//
// one item accepted per cycle while in_stall is low
// the pipe runs through the 33-stage square root and the FRAC_BITS + 3 stage dividers
// rst clears all valid bits; data registers are not reset
// out_stall with a valid result freezes every stage and raises in_stall
module elastic_circle_collision_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic [30:0]        first_mass,
  input  logic [30:0]        first_radius,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic [30:0]        second_mass,
  input  logic [30:0]        second_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               degenerate,
  output logic signed [31:0] new_first_pos_x,
  output logic signed [31:0] new_first_pos_y,
  output logic signed [31:0] new_first_vel_x,
  output logic signed [31:0] new_first_vel_y,
  output logic signed [31:0] new_second_vel_x,
  output logic signed [31:0] new_second_vel_y
);

  localparam int FW      = FRAC_BITS + 3;
  localparam int PW      = FW + 37;
  localparam int UW      = 35;
  localparam int NV      = 36;
  localparam int SQ_LAT  = ecc_pkg::DIST_W;
  localparam int DIV_LAT = FRAC_BITS + 3;
  localparam int SW      = ecc_pkg::SAT_W;
  localparam int DW      = ecc_pkg::DIST_W;
  localparam logic signed [PW-1:0] RND = (PW'(1) <<< FRAC_BITS) - PW'(1);
  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;

  // truncate x / 2^F toward zero
  function automatic logic signed [PW-1:0] scale_dn(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] b;
    b = x[PW-1] ? RND : '0;
    return (x + b) >>> FRAC_BITS;
  endfunction

  logic en;

  // global advance: only a held result stops the pipe
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // entry: differences, magnitudes, mass terms
  ecc_pkg::side_t     in_sd;
  logic signed [32:0] dx;
  logic signed [32:0] dy;

  always_comb begin
    dx = 33'(first_pos_x) - 33'(second_pos_x);
    dy = 33'(first_pos_y) - 33'(second_pos_y);
    in_sd        = '0;
    in_sd.p1x    = first_pos_x;
    in_sd.p1y    = first_pos_y;
    in_sd.v1x    = first_vel_x;
    in_sd.v1y    = first_vel_y;
    in_sd.v2x    = second_vel_x;
    in_sd.v2y    = second_vel_y;
    in_sd.rsum   = 32'(first_radius) + 32'(second_radius);
    in_sd.msum   = 32'(first_mass) + 32'(second_mass);
    in_sd.mneg   = (first_mass < second_mass);
    in_sd.mdiff  = in_sd.mneg ? (second_mass - first_mass) : (first_mass - second_mass);
    in_sd.m1     = first_mass;
    in_sd.m2     = second_mass;
    in_sd.dx_neg = dx[32];
    in_sd.dy_neg = dy[32];
    in_sd.ax     = dx[32] ? DW'(-dx) : DW'(dx);
    in_sd.ay     = dy[32] ? DW'(-dy) : DW'(dy);
  end

  // front stages and squares
  ecc_pkg::side_t            s1_sd, s2_sd, s3_sd;
  logic                      s1_v, s2_v, s3_v;
  logic [ecc_pkg::SQ_W-1:0]  s2_sqx, s2_sqy, s3_sum;

  // sqrt and divider side lines
  ecc_pkg::side_t sq_sd [0:SQ_LAT];
  logic           sq_v  [0:SQ_LAT];
  ecc_pkg::side_t dv_sd [0:DIV_LAT];
  logic           dv_v  [0:DIV_LAT];
  logic [DW-1:0]  sep;

  assign sq_sd[0] = s3_sd;
  assign sq_v[0]  = s3_v;

  ecc_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3_sum),
    .root (sep)
  );

  // item data beside the square root
  for (genvar k = 1; k <= SQ_LAT; k++) begin : g_sq_line
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= sq_v[k-1];
      end
      if (en) begin
        sq_sd[k] <= sq_sd[k-1];
      end
    end
  end

  // overlap test at divider entry
  always_comb begin
    dv_sd[0]     = sq_sd[SQ_LAT];
    dv_sd[0].deg = (sep == '0);
    dv_sd[0].hit = (sep != '0) && (sep < DW'(sq_sd[SQ_LAT].rsum));
    dv_sd[0].ov  = 34'(sq_sd[SQ_LAT].rsum) - 34'(sep);
  end
  assign dv_v[0] = sq_v[SQ_LAT];

  // item data beside the dividers
  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_dv_line
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= dv_v[k-1];
      end
      if (en) begin
        dv_sd[k] <= dv_sd[k-1];
      end
    end
  end

  logic signed [FW-1:0] q_nx, q_ny, q_fd, q_f1, q_f2;

  ecc_div #(.FRAC_BITS(FRAC_BITS)) u_div_nx (
    .clk (clk), .en (en), .num (dv_sd[0].ax), .neg (dv_sd[0].dx_neg),
    .den (sep), .quo (q_nx)
  );
  ecc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ny (
    .clk (clk), .en (en), .num (dv_sd[0].ay), .neg (dv_sd[0].dy_neg),
    .den (sep), .quo (q_ny)
  );
  ecc_div #(.FRAC_BITS(FRAC_BITS)) u_div_fd (
    .clk (clk), .en (en), .num (DW'(dv_sd[0].mdiff)), .neg (dv_sd[0].mneg),
    .den (DW'(dv_sd[0].msum)), .quo (q_fd)
  );
  ecc_div #(.FRAC_BITS(FRAC_BITS)) u_div_f1 (
    .clk (clk), .en (en), .num (DW'({dv_sd[0].m2, 1'b0})), .neg (1'b0),
    .den (DW'(dv_sd[0].msum)), .quo (q_f1)
  );
  ecc_div #(.FRAC_BITS(FRAC_BITS)) u_div_f2 (
    .clk (clk), .en (en), .num (DW'({dv_sd[0].m1, 1'b0})), .neg (1'b0),
    .den (DW'(dv_sd[0].msum)), .quo (q_f2)
  );

  // math stages
  ecc_pkg::side_t          m1_sd, m2_sd, m3_sd, m4_sd, m5_sd;
  logic                    m1_v, m2_v, m3_v, m4_v, m5_v;
  logic signed [FW-1:0]    m1_nx, m1_ny, m1_fd, m1_f1, m1_f2;
  logic signed [FW-1:0]    m2_nx, m2_ny, m2_fd, m2_f1, m2_f2;
  logic signed [FW-1:0]    m3_nx, m3_ny, m4_nx, m4_ny;
  logic signed [31+FW:0]   m1_a1, m1_b1, m1_c1, m1_d1, m1_a2, m1_b2, m1_c2, m1_d2;
  logic signed [33+FW:0]   m1_ox, m1_oy;
  logic signed [UW-1:0]    m2_u1, m2_u2, m2_w1, m2_w2;
  logic signed [UW-1:0]    m3_w1, m3_w2, m4_w1, m4_w2;
  logic signed [31:0]      m2_px, m2_py, m3_px, m3_py, m4_px, m4_py, m5_px, m5_py;
  logic signed [UW+FW-1:0] m3_g1, m3_g2, m3_g3, m3_g4;
  logic signed [NV-1:0]    m4_n1, m4_n2;
  logic signed [NV+FW-1:0] m5_e1, m5_e3, m5_e5, m5_e7;
  logic signed [UW+FW-1:0] m5_e2, m5_e4, m5_e6, m5_e8;

  logic                    fz;
  assign fz = (dv_sd[DIV_LAT].msum == '0);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      m3_v      <= 1'b0;
      m4_v      <= 1'b0;
      m5_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      m1_v      <= dv_v[DIV_LAT];
      m2_v      <= m1_v;
      m3_v      <= m2_v;
      m4_v      <= m3_v;
      m5_v      <= m4_v;
      out_valid <= m5_v;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      // squares and their sum
      s1_sd  <= in_sd;
      s2_sd  <= s1_sd;
      s2_sqx <= ecc_pkg::SQ_W'(s1_sd.ax) * ecc_pkg::SQ_W'(s1_sd.ax);
      s2_sqy <= ecc_pkg::SQ_W'(s1_sd.ay) * ecc_pkg::SQ_W'(s1_sd.ay);
      s3_sd  <= s2_sd;
      s3_sum <= s2_sqx + s2_sqy;

      // projections onto the normal, overlap push
      m1_sd <= dv_sd[DIV_LAT];
      m1_nx <= q_nx;
      m1_ny <= q_ny;
      m1_fd <= fz ? '0 : q_fd;
      m1_f1 <= fz ? ONE : q_f1;
      m1_f2 <= fz ? ONE : q_f2;
      m1_a1 <= dv_sd[DIV_LAT].v1x * q_nx;
      m1_b1 <= dv_sd[DIV_LAT].v1y * q_ny;
      m1_c1 <= dv_sd[DIV_LAT].v1y * q_nx;
      m1_d1 <= dv_sd[DIV_LAT].v1x * q_ny;
      m1_a2 <= dv_sd[DIV_LAT].v2x * q_nx;
      m1_b2 <= dv_sd[DIV_LAT].v2y * q_ny;
      m1_c2 <= dv_sd[DIV_LAT].v2y * q_nx;
      m1_d2 <= dv_sd[DIV_LAT].v2x * q_ny;
      m1_ox <= dv_sd[DIV_LAT].ov * q_nx;
      m1_oy <= dv_sd[DIV_LAT].ov * q_ny;

      // normal and tangential speeds, new position
      m2_sd <= m1_sd;
      m2_nx <= m1_nx;
      m2_ny <= m1_ny;
      m2_fd <= m1_fd;
      m2_f1 <= m1_f1;
      m2_f2 <= m1_f2;
      m2_u1 <= UW'(scale_dn(PW'(m1_a1) + PW'(m1_b1)));
      m2_w1 <= UW'(scale_dn(PW'(m1_c1) - PW'(m1_d1)));
      m2_u2 <= UW'(scale_dn(PW'(m1_a2) + PW'(m1_b2)));
      m2_w2 <= UW'(scale_dn(PW'(m1_c2) - PW'(m1_d2)));
      m2_px <= ecc_pkg::sat32(SW'(PW'(m1_sd.p1x) + scale_dn(PW'(m1_ox))));
      m2_py <= ecc_pkg::sat32(SW'(PW'(m1_sd.p1y) + scale_dn(PW'(m1_oy))));

      // mass factor products
      m3_sd <= m2_sd;
      m3_nx <= m2_nx;
      m3_ny <= m2_ny;
      m3_w1 <= m2_w1;
      m3_w2 <= m2_w2;
      m3_px <= m2_px;
      m3_py <= m2_py;
      m3_g1 <= m2_fd * m2_u1;
      m3_g2 <= m2_f1 * m2_u2;
      m3_g3 <= m2_f2 * m2_u1;
      m3_g4 <= m2_fd * m2_u2;

      // exchanged normal speeds
      m4_sd <= m3_sd;
      m4_nx <= m3_nx;
      m4_ny <= m3_ny;
      m4_w1 <= m3_w1;
      m4_w2 <= m3_w2;
      m4_px <= m3_px;
      m4_py <= m3_py;
      m4_n1 <= NV'(scale_dn(PW'(m3_g1) + PW'(m3_g2)));
      m4_n2 <= NV'(scale_dn(PW'(m3_g3) - PW'(m3_g4)));

      // back to x and y
      m5_sd <= m4_sd;
      m5_px <= m4_px;
      m5_py <= m4_py;
      m5_e1 <= m4_n1 * m4_nx;
      m5_e2 <= m4_w1 * m4_ny;
      m5_e3 <= m4_n1 * m4_ny;
      m5_e4 <= m4_w1 * m4_nx;
      m5_e5 <= m4_n2 * m4_nx;
      m5_e6 <= m4_w2 * m4_ny;
      m5_e7 <= m4_n2 * m4_ny;
      m5_e8 <= m4_w2 * m4_nx;

      // result register, pass-through when no hit
      hit        <= m5_sd.hit;
      degenerate <= m5_sd.deg;
      if (m5_sd.hit) begin
        new_first_pos_x  <= m5_px;
        new_first_pos_y  <= m5_py;
        new_first_vel_x  <= ecc_pkg::sat32(SW'(scale_dn(PW'(m5_e1) - PW'(m5_e2))));
        new_first_vel_y  <= ecc_pkg::sat32(SW'(scale_dn(PW'(m5_e3) + PW'(m5_e4))));
        new_second_vel_x <= ecc_pkg::sat32(SW'(scale_dn(PW'(m5_e5) - PW'(m5_e6))));
        new_second_vel_y <= ecc_pkg::sat32(SW'(scale_dn(PW'(m5_e7) + PW'(m5_e8))));
      end else begin
        new_first_pos_x  <= m5_sd.p1x;
        new_first_pos_y  <= m5_sd.p1y;
        new_first_vel_x  <= m5_sd.v1x;
        new_first_vel_y  <= m5_sd.v1y;
        new_second_vel_x <= m5_sd.v2x;
        new_second_vel_y <= m5_sd.v2y;
      end
    end
  end

endmodule

[rtl/ecc_sqrt.sv]
`timescale 1ns / 1ps
// floor square root, two radicand bits per stage
module ecc_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ecc_pkg::SQ_W-1:0]    rad,
  output logic [ecc_pkg::DIST_W-1:0]  root
);

  localparam int N     = ecc_pkg::DIST_W;
  localparam int SW    = ecc_pkg::SQ_W;
  localparam int REM_W = N + 2;

  logic [REM_W-1:0] rem [0:N];
  logic [N-1:0]     rt  [0:N];
  logic [SW-1:0]    rd  [0:N];

  logic [REM_W-1:0] rem_next [0:N-1];
  logic [N-1:0]     rt_next  [0:N-1];
  logic [SW-1:0]    rd_next  [0:N-1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;

  // one restoring step per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [REM_W+1:0] rs;
      logic [REM_W+1:0] trial;
      logic             ge;
      rs    = {rem[k], rd[k][SW-1:SW-2]};
      trial = (REM_W+2)'({rt[k], 2'b01});
      ge    = (rs >= trial);
      rem_next[k] = ge ? REM_W'(rs - trial) : REM_W'(rs);
      rt_next[k]  = {rt[k][N-2:0], ge};
      rd_next[k]  = rd[k] << 2;
    end
  end

  // stage registers
  for (genvar k = 1; k <= N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= rem_next[k-1];
        rt[k]  <= rt_next[k-1];
        rd[k]  <= rd_next[k-1];
      end
    end
  end

  assign root = rt[N];

endmodule

[rtl/ecc_div.sv]
`timescale 1ns / 1ps
// signed (num << FRAC_BITS) / den, one quotient bit per stage, then sign
module ecc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ecc_pkg::DIST_W-1:0]    num,
  input  logic                          neg,
  input  logic [ecc_pkg::DIST_W-1:0]    den,
  output logic signed [FRAC_BITS+2:0]   quo
);

  localparam int Q_W = FRAC_BITS + 2;
  localparam int D_W = ecc_pkg::DIST_W;

  logic [D_W-1:0] rem  [0:Q_W];
  logic [Q_W-1:0] qb   [0:Q_W];
  logic [Q_W-1:0] low  [0:Q_W];
  logic [D_W-1:0] dn   [0:Q_W];
  logic           sg   [0:Q_W];

  logic [D_W-1:0] rem_next [0:Q_W-1];
  logic [Q_W-1:0] qb_next  [0:Q_W-1];
  logic [Q_W-1:0] low_next [0:Q_W-1];

  // quotient stays below 2^Q_W, so the top bits start as the remainder
  assign rem[0] = num >> 2;
  assign qb[0]  = '0;
  assign low[0] = {num[1:0], {FRAC_BITS{1'b0}}};
  assign dn[0]  = den;
  assign sg[0]  = neg;

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      logic [D_W:0] rs;
      logic         ge;
      rs = {rem[k], low[k][Q_W-1]};
      ge = (rs >= {1'b0, dn[k]});
      rem_next[k] = ge ? D_W'(rs - {1'b0, dn[k]}) : D_W'(rs);
      qb_next[k]  = {qb[k][Q_W-2:0], ge};
      low_next[k] = low[k] << 1;
    end
  end

  // stage registers
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= rem_next[k-1];
        qb[k]  <= qb_next[k-1];
        low[k] <= low_next[k-1];
        dn[k]  <= dn[k-1];
        sg[k]  <= sg[k-1];
      end
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= sg[Q_W] ? -$signed({1'b0, qb[Q_W]}) : $signed({1'b0, qb[Q_W]});
    end
  end

endmodule

[rtl/ecc_checker.sv]
`timescale 1ns / 1ps
`include "elastic_circle_collision_core_assert.svh"
// port-level checks on the collision core
module ecc_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit,
  input logic degenerate
);

  // a result cannot be both resolved and degenerate
  `ECC_AST_IMP(a_flags_excl, clk, rst, out_valid, !(hit && degenerate), "hit with degenerate")

  // input only backs up behind a held result
  `ECC_AST_IMP(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "stall without cause")

  // a held result stays offered
  `ECC_AST_NXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid, "result dropped")

  // nothing comes out right after reset
  `ECC_AST_IMP(a_reset_empty, clk, rst, $past(rst), !out_valid, "result after reset")

endmodule

bind elastic_circle_collision_core ecc_checker u_ecc_checker (.*);
